@@ src/jacobi_stencil_sweep_macros.svh @@
// Assertion macros for the checker file of the stencil sweep block.
// Depends on nothing; included by the checker after its module header.
`ifndef JACOBI_STENCIL_SWEEP_MACROS_SVH
`define JACOBI_STENCIL_SWEEP_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge and switched off during reset.
`define JSS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked while reset is applied.
`define JSS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/jss_pkg.sv @@
// Shared definitions for the Jacobi stencil sweep block.
// Holds the register index codes of the configuration port; depends on nothing.
package jss_pkg;

   typedef enum logic [0:0] {
      CSR_GRID_WIDTH  = 1'b0,
      CSR_GRID_HEIGHT = 1'b1
   } csr_index_type;

endpackage

@@ src/jacobi_stencil_sweep.sv @@
// Jacobi 5-point stencil sweep: takes one grid cell per request in row-major order and
// returns the updated value of the cell one row above. Outside the last row, the block takes
// one cell per clock while the result channel does not stall. A request's result passes
// through a line-buffer read stage and then the result register. Cells of the last row cause
// two results each, which share the single result register, so that row takes a new cell
// only after both results of the previous cell have entered it. Interior cells become
// the floor of the mean of their four neighbours, border cells pass through unchanged.
// Two line buffers of MAX_WIDTH words hold the previous two rows; they are not cleared, and
// an entry read before it was first written (possible only if the width grows during a
// sweep) returns an undefined value. Width and height are saturated into their legal ranges.
// The user must write configuration only while no request is in flight (not enforced here).
// Depends on jss_pkg for the register index codes.
module jacobi_stencil_sweep #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096,
   parameter int VALUE_BITS = 32
) (
   input  logic clock,
   input  logic reset,
   // Request channel.
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] req_tdata,  // cell_value
   // Result channel.
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // new_value, out_row, out_col (lowest bits first)
   output logic [((VALUE_BITS + $clog2(MAX_HEIGHT) + $clog2(MAX_WIDTH) + 7) / 8) * 8 - 1:0]
      rsp_tdata,
   output logic rsp_tlast,   // item_last
   output logic rsp_tuser,   // sweep_done
   // Configuration port.
   input  logic csr_we,
   input  jss_pkg::csr_index_type csr_addr,
   input  logic [(($clog2(MAX_HEIGHT) > $clog2(MAX_WIDTH)) ?
                  $clog2(MAX_HEIGHT) : $clog2(MAX_WIDTH)):0] csr_wdata
);
   import jss_pkg::*;

   localparam int COL_BITS      = $clog2(MAX_WIDTH);
   localparam int ROW_BITS      = $clog2(MAX_HEIGHT);
   localparam int WREG_BITS     = COL_BITS + 1;
   localparam int HREG_BITS     = ROW_BITS + 1;
   localparam int RSP_DATA_BITS = ((VALUE_BITS + ROW_BITS + COL_BITS + 7) / 8) * 8;
   localparam logic [WREG_BITS-1:0] WIDTH_RESET  = WREG_BITS'((MAX_WIDTH < 16) ? MAX_WIDTH : 16);
   localparam logic [HREG_BITS-1:0] HEIGHT_RESET =
      HREG_BITS'((MAX_HEIGHT < 16) ? MAX_HEIGHT : 16);
   localparam logic [WREG_BITS-1:0] WIDTH_MIN  = WREG_BITS'(3);
   localparam logic [WREG_BITS-1:0] WIDTH_MAX  = WREG_BITS'(MAX_WIDTH);
   localparam logic [HREG_BITS-1:0] HEIGHT_MIN = HREG_BITS'(3);
   localparam logic [HREG_BITS-1:0] HEIGHT_MAX = HREG_BITS'(MAX_HEIGHT);

   // Configuration registers.
   logic [WREG_BITS-1:0] width_ff;
   logic [HREG_BITS-1:0] height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_GRID_WIDTH:  width_ff  <= csr_wdata[WREG_BITS-1:0];
            CSR_GRID_HEIGHT: height_ff <= csr_wdata[HREG_BITS-1:0];
         endcase
      end
   end

   logic [WREG_BITS-1:0] width_eff;
   logic [HREG_BITS-1:0] height_eff;
   logic [WREG_BITS-1:0] width_last;
   logic [HREG_BITS-1:0] height_last;

   always_comb begin
      priority if (width_ff < WIDTH_MIN) width_eff = WIDTH_MIN;
      else if (width_ff > WIDTH_MAX)     width_eff = WIDTH_MAX;
      else                               width_eff = width_ff;
      priority if (height_ff < HEIGHT_MIN) height_eff = HEIGHT_MIN;
      else if (height_ff > HEIGHT_MAX)     height_eff = HEIGHT_MAX;
      else                                 height_eff = height_ff;
      width_last  = width_eff - WREG_BITS'(1);
      height_last = height_eff - HREG_BITS'(1);
   end

   // Position counters of the next request.
   logic [COL_BITS-1:0] col_ff;
   logic [ROW_BITS-1:0] row_ff;
   logic                last_col;
   logic                last_row;
   logic [COL_BITS-1:0] col_x;
   logic [COL_BITS-1:0] col_right;
   logic                accept;
   logic [VALUE_BITS-1:0] cell_in;

   assign last_col  = {1'b0, col_ff} >= width_last;
   assign last_row  = {1'b0, row_ff} >= height_last;
   assign col_x     = last_col ? width_last[COL_BITS-1:0] : col_ff;
   assign col_right = col_x + COL_BITS'(1);
   assign accept    = req_tvalid && req_tready;
   assign cell_in   = req_tdata[VALUE_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         if (last_col) begin
            col_ff <= '0;
            row_ff <= last_row ? '0 : row_ff + ROW_BITS'(1);
         end else begin
            col_ff <= col_x + COL_BITS'(1);
         end
      end
   end

   // Line buffers. The recent row is read at the cell and its right neighbour and takes the
   // new cell at once; the older row takes the displaced recent entry in the following cycle.
   logic [VALUE_BITS-1:0] recent_mem [MAX_WIDTH];
   logic [VALUE_BITS-1:0] older_mem  [MAX_WIDTH];
   logic [VALUE_BITS-1:0] rd_centre_ff;
   logic [VALUE_BITS-1:0] rd_right_ff;
   logic [VALUE_BITS-1:0] rd_up_ff;
   logic                  wr_pend_ff;
   logic [COL_BITS-1:0]   s1_col_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         recent_mem[col_x] <= cell_in;
         rd_centre_ff      <= recent_mem[col_x];
         rd_right_ff       <= recent_mem[col_right];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_up_ff <= older_mem[col_x];
      end
      if (wr_pend_ff) begin
         older_mem[s1_col_ff] <= rd_centre_ff;
      end
   end

   // Read stage: one request waiting for its results to enter the result register.
   logic                  s1_valid_ff;
   logic                  s1_second_ff;
   logic [VALUE_BITS-1:0] s1_value_ff;
   logic [ROW_BITS-1:0]   s1_row_ff;
   logic                  s1_last_col_ff;
   logic                  s1_last_row_ff;
   logic [VALUE_BITS-1:0] left_ff;

   logic                  has_above;
   logic                  has_own;
   logic                  no_result;
   logic                  border;
   logic                  out_free;
   logic                  emit;
   logic                  emit_own;
   logic                  emit_last;
   logic                  s1_done;
   logic signed [VALUE_BITS+1:0] nb_sum;
   logic [VALUE_BITS-1:0] above_value;

   always_comb begin
      has_above = s1_row_ff != '0;
      has_own   = s1_last_row_ff;
      no_result = !has_above && !has_own;
      border    = (s1_row_ff == ROW_BITS'(1)) || (s1_col_ff == '0) || s1_last_col_ff;
      nb_sum    = $signed({{2{rd_up_ff[VALUE_BITS-1]}}, rd_up_ff})
                + $signed({{2{s1_value_ff[VALUE_BITS-1]}}, s1_value_ff})
                + $signed({{2{left_ff[VALUE_BITS-1]}}, left_ff})
                + $signed({{2{rd_right_ff[VALUE_BITS-1]}}, rd_right_ff});
      // Dropping the two low bits of the exact sum gives the floor of the mean.
      above_value = border ? rd_centre_ff : nb_sum[VALUE_BITS+1:2];
      out_free  = !rsp_tvalid || rsp_tready;
      emit_own  = s1_second_ff || !has_above;
      emit_last = emit_own || !has_own;
      emit      = s1_valid_ff && !no_result && out_free;
      s1_done   = s1_valid_ff && (no_result || (out_free && emit_last));
   end

   assign req_tready = !s1_valid_ff || s1_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s1_second_ff <= 1'b0;
         wr_pend_ff   <= 1'b0;
      end else begin
         wr_pend_ff <= accept;
         if (accept) begin
            s1_valid_ff  <= 1'b1;
            s1_second_ff <= 1'b0;
         end else begin
            if (s1_done) begin
               s1_valid_ff <= 1'b0;
            end
            if (emit && !emit_last) begin
               s1_second_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_value_ff    <= cell_in;
         s1_col_ff      <= col_x;
         s1_row_ff      <= row_ff;
         s1_last_col_ff <= last_col;
         s1_last_row_ff <= last_row;
      end
      // The retiring cell is the left neighbour of the next one in its row.
      if (s1_done) begin
         left_ff <= rd_centre_ff;
      end
   end

   // Result register.
   logic                  rsp_valid_ff;
   logic [VALUE_BITS-1:0] rsp_value_ff;
   logic [ROW_BITS-1:0]   rsp_row_ff;
   logic [COL_BITS-1:0]   rsp_col_ff;
   logic                  rsp_last_ff;
   logic                  rsp_done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_value_ff <= emit_own ? s1_value_ff : above_value;
         rsp_row_ff   <= emit_own ? s1_row_ff : s1_row_ff - ROW_BITS'(1);
         rsp_col_ff   <= s1_col_ff;
         rsp_last_ff  <= emit_last;
         rsp_done_ff  <= emit_own && s1_last_col_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({rsp_col_ff, rsp_row_ff, rsp_value_ff});
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_done_ff;

endmodule

@@ src/jss_checker.sv @@
// Port-level checker for the Jacobi stencil sweep block, bound to the top level.
// Depends on jacobi_stencil_sweep_macros.svh and on the top level's request-ready and result ports.
module jss_checker #(
   parameter int DATA_BITS = 56
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tready,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [DATA_BITS-1:0] rsp_tdata,
   input logic                 rsp_tlast,
   input logic                 rsp_tuser
);
`include "jacobi_stencil_sweep_macros.svh"

   // A stalled result keeps its contents until it is taken.
   `JSS_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser), "stalled result changed")

   // The end of a sweep is always the last result of its request.
   `JSS_ASSERT(a_done_is_last, clock, reset, rsp_tvalid && rsp_tuser |-> rsp_tlast, "sweep end without last flag")

   // Reset empties the pipeline and leaves the request side open.
   `JSS_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid && req_tready, "pipeline not empty after reset")

endmodule

bind jacobi_stencil_sweep jss_checker #(
   .DATA_BITS(RSP_DATA_BITS)
) u_jss_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
